// File: hdl/tsb_pkg.sv
// ----------------------------------------------------------------------------
// tsb_pkg
// Types and constants shared by the three-stack buffer controller, datapath
// and top level.
// ----------------------------------------------------------------------------
package tsb_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int DATA_W    = 32;

    typedef enum logic {
        ACT_PUSH = 1'b0,
        ACT_POP  = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        SEL_BOTTOM = 2'd0,
        SEL_TOP    = 2'd1,
        SEL_MIDDLE = 2'd2
    } t_sel;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_OVER  = 2'd1,
        ST_UNDER = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADDR,
        S_CHECK,
        S_EXEC,
        S_RESP
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic calc_addr;
        logic calc_occ;
        logic exec;
        logic load_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

// File: hdl/tsb_ctrl.sv
// ----------------------------------------------------------------------------
// tsb_ctrl
// Sequencer for one push or pop: address, conflict check, memory access and
// result hand-off.
// ----------------------------------------------------------------------------
module tsb_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  tsb_pkg::t_dp_status   i_status,
    output tsb_pkg::t_cmd         o_cmd
);

    tsb_pkg::t_state r_state;
    tsb_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tsb_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_s_axis_tready = 1'b0;
        unique case (r_state)
            tsb_pkg::S_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = tsb_pkg::S_ADDR;
                end
            end
            tsb_pkg::S_ADDR: begin
                o_cmd.calc_addr = 1'b1;
                n_state         = tsb_pkg::S_CHECK;
            end
            tsb_pkg::S_CHECK: begin
                o_cmd.calc_occ = 1'b1;
                n_state        = tsb_pkg::S_EXEC;
            end
            tsb_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = tsb_pkg::S_RESP;
            end
            tsb_pkg::S_RESP: begin
                // Wait here while the previous result is still unclaimed.
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = tsb_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tsb_pkg::S_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("more than one datapath command at once");

    a_resp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tsb_pkg::S_RESP && !i_status.out_free) |=>
        (r_state == tsb_pkg::S_RESP))
        else $error("result dropped while output register was full");
`endif

endmodule

// File: hdl/tsb_datapath.sv
// ----------------------------------------------------------------------------
// tsb_datapath
// Shared word memory, the three stack counters, address and conflict logic,
// and the output register.
// ----------------------------------------------------------------------------
module tsb_datapath #(
    parameter int DEPTH = tsb_pkg::DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tsb_pkg::t_cmd                i_cmd,
    output tsb_pkg::t_dp_status          o_status,
    input  logic [2:0]                   i_s_axis_tuser,
    input  logic [tsb_pkg::DATA_W-1:0]   i_s_axis_tdata,
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    output logic [tsb_pkg::DATA_W-1:0]   o_m_axis_tdata,
    output logic [1:0]                   o_m_axis_tuser
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = CW + 1;

    localparam logic [EW-1:0] K_DEPTH = EW'(DEPTH);
    localparam logic [EW-1:0] K_C     = EW'(DEPTH / 2);
    localparam logic [EW-1:0] K_HI    = EW'(DEPTH - DEPTH / 2);
    localparam logic [EW-1:0] K_ONE   = EW'(1);

    logic [tsb_pkg::DATA_W-1:0] r_mem [DEPTH];

    logic [CW-1:0]              r_bc;
    logic [CW-1:0]              r_tc;
    logic [CW-1:0]              r_mc;

    tsb_pkg::t_action           r_action;
    tsb_pkg::t_sel              r_sel;
    logic                       r_sel_ok;
    logic [tsb_pkg::DATA_W-1:0] r_value;

    logic [EW-1:0]              r_addr;
    logic                       r_ok_a;
    logic                       r_ok;
    logic [tsb_pkg::DATA_W-1:0] r_rdata;

    logic                       r_out_valid;
    logic [tsb_pkg::DATA_W-1:0] r_out_data;
    tsb_pkg::t_status           r_out_status;

    logic [EW-1:0] bc_e;
    logic [EW-1:0] tc_e;
    logic [EW-1:0] mc_e;
    logic [EW-1:0] n_addr;
    logic          n_ok_a;
    logic          occ;

    assign bc_e = EW'(r_bc);
    assign tc_e = EW'(r_tc);
    assign mc_e = EW'(r_mc);

    // Input capture; a selector value of 3 names no stack, so the operation is refused.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_action <= tsb_pkg::t_action'(i_s_axis_tuser[0]);
            r_sel    <= tsb_pkg::t_sel'(i_s_axis_tuser[2:1]);
            r_sel_ok <= (i_s_axis_tuser[2:1] != 2'd3);
            r_value  <= i_s_axis_tdata;
        end
    end

    // Slot addressed by the operation and whether the stack allows it.
    // The middle stack fills centre, centre+1, centre-1, centre+2, and so on.
    always_comb begin
        n_addr = '0;
        n_ok_a = 1'b0;
        if (r_sel_ok) begin
            if (r_action == tsb_pkg::ACT_PUSH) begin
                unique case (r_sel)
                    tsb_pkg::SEL_BOTTOM: begin
                        n_addr = bc_e;
                        n_ok_a = bc_e < K_DEPTH;
                    end
                    tsb_pkg::SEL_TOP: begin
                        n_addr = K_DEPTH - K_ONE - tc_e;
                        n_ok_a = tc_e < K_DEPTH;
                    end
                    tsb_pkg::SEL_MIDDLE: begin
                        if (r_mc[0]) begin
                            n_addr = K_C + ((mc_e + K_ONE) >> 1);
                            n_ok_a = ((mc_e + K_ONE) >> 1) < K_HI;
                        end else begin
                            n_addr = K_C - (mc_e >> 1);
                            n_ok_a = (mc_e >> 1) <= K_C;
                        end
                    end
                    default: begin
                        n_ok_a = 1'b0;
                    end
                endcase
            end else begin
                unique case (r_sel)
                    tsb_pkg::SEL_BOTTOM: begin
                        n_addr = bc_e - K_ONE;
                        n_ok_a = r_bc != '0;
                    end
                    tsb_pkg::SEL_TOP: begin
                        n_addr = K_DEPTH - tc_e;
                        n_ok_a = r_tc != '0;
                    end
                    tsb_pkg::SEL_MIDDLE: begin
                        // Top element index is count-1; its parity picks the side.
                        if (r_mc[0]) begin
                            n_addr = K_C - ((mc_e - K_ONE) >> 1);
                        end else begin
                            n_addr = K_C + (mc_e >> 1);
                        end
                        n_ok_a = r_mc != '0;
                    end
                    default: begin
                        n_ok_a = 1'b0;
                    end
                endcase
            end
        end
    end

    // A slot is taken when it lies inside any stack's current span.
    always_comb begin
        occ = (r_addr < bc_e)
            || ((r_tc != '0) && (r_addr + tc_e >= K_DEPTH))
            || ((r_mc != '0) && (r_addr + ((mc_e - K_ONE) >> 1) >= K_C)
                && (r_addr <= K_C + (mc_e >> 1)));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc_addr) begin
            r_addr <= n_addr;
            r_ok_a <= n_ok_a;
        end
        if (i_cmd.calc_occ) begin
            r_ok <= r_ok_a && ((r_action == tsb_pkg::ACT_POP) || !occ);
        end
    end

    // Shared memory: at most one write and one registered read per operation.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            if (r_ok && r_action == tsb_pkg::ACT_PUSH) begin
                r_mem[r_addr[AW-1:0]] <= r_value;
            end
            r_rdata <= r_mem[r_addr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bc <= '0;
            r_tc <= '0;
            r_mc <= '0;
        end else if (i_cmd.exec && r_ok) begin
            unique case (r_sel)
                tsb_pkg::SEL_BOTTOM: begin
                    r_bc <= (r_action == tsb_pkg::ACT_PUSH) ? r_bc + CW'(1) : r_bc - CW'(1);
                end
                tsb_pkg::SEL_TOP: begin
                    r_tc <= (r_action == tsb_pkg::ACT_PUSH) ? r_tc + CW'(1) : r_tc - CW'(1);
                end
                tsb_pkg::SEL_MIDDLE: begin
                    r_mc <= (r_action == tsb_pkg::ACT_PUSH) ? r_mc + CW'(1) : r_mc - CW'(1);
                end
                default: begin
                    r_bc <= r_bc;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data <= (r_ok && r_action == tsb_pkg::ACT_POP) ? r_rdata : '0;
            if (r_ok) begin
                r_out_status <= tsb_pkg::ST_DONE;
            end else if (r_action == tsb_pkg::ACT_PUSH) begin
                r_out_status <= tsb_pkg::ST_OVER;
            end else begin
                r_out_status <= tsb_pkg::ST_UNDER;
            end
        end
    end

    assign o_status.out_free = !r_out_valid || i_m_axis_tready;
    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = r_out_data;
    assign o_m_axis_tuser    = r_out_status;

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((EW + 1)'(r_bc) + (EW + 1)'(r_tc) + (EW + 1)'(r_mc)) <= (EW + 1)'(DEPTH))
        else $error("stacks hold more words than the memory has");

    a_out_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |=> r_out_valid)
        else $error("result load did not raise the output valid");
`endif

endmodule

// File: hdl/three_stacks_shared_buffer.sv
// A word accepted in idle passes through the controller's address, conflict
// check, memory access and result load states before its result is presented;
// a new input word is accepted only once the controller is back in idle.
// A full output register holds the controller until the result is taken.
// Reset (i_rst_n low, synchronous) empties all three stacks; memory contents
// are not cleared and no clearing pass runs.
// ----------------------------------------------------------------------------
// three_stacks_shared_buffer
// Three push/pop stacks in one shared memory: bottom grows up, top grows down,
// middle alternates around the centre.
// ----------------------------------------------------------------------------
module three_stacks_shared_buffer #(
    parameter int DEPTH = tsb_pkg::DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [tsb_pkg::DATA_W-1:0]  i_s_axis_tdata,   // [31:0] push_value
    input  logic [2:0]                  i_s_axis_tuser,   // [0] action, [2:1] stack_select
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [tsb_pkg::DATA_W-1:0]  o_m_axis_tdata,   // [31:0] pop_value
    output logic [1:0]                  o_m_axis_tuser    // [1:0] status
);

    tsb_pkg::t_cmd       cmd;
    tsb_pkg::t_dp_status dp_status;

    tsb_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_status        (dp_status),
        .o_cmd           (cmd)
    );

    tsb_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (dp_status),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule
